### hw/rtl/hgc_pkg.sv
// hgc_pkg: widths, register indexes and reset values of the height to gradient color block
// used by the interfaces, the cells, the blend stage and the top level
package hgc_pkg;

    localparam int HEIGHT_W  = 16;
    localparam int COLOR_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = COLOR_W / CHAN_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HEIGHT_LOW  = 3'd0;
    localparam t_cfg_idx CFG_HEIGHT_HIGH = 3'd1;
    localparam t_cfg_idx CFG_START_COLOR = 3'd2;
    localparam t_cfg_idx CFG_END_COLOR   = 3'd3;

    localparam logic [COLOR_W-1:0] START_COLOR_RST = 32'h0000_00FF;
    localparam logic [COLOR_W-1:0] END_COLOR_RST   = 32'h00FF_0000;

    // one division item as it moves down the row of cells
    typedef struct packed {
        logic [HEIGHT_W-1:0] rem;
        logic [HEIGHT_W-1:0] den;
    } t_div_item;

endpackage

### hw/rtl/hgc_height_if.sv
// hgc_height_if: valid/ready channel carrying one signed height sample
// depends on hgc_pkg for the field width
interface hgc_height_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hgc_pkg::HEIGHT_W-1:0]  height;

    modport source (output valid, output height, input ready);
    modport sink   (input valid, input height, output ready);
endinterface

### hw/rtl/hgc_color_if.sv
// hgc_color_if: valid/ready channel carrying one packed T,R,G,B color
// depends on hgc_pkg for the field width
interface hgc_color_if;
    logic                          valid;
    logic                          ready;
    logic [hgc_pkg::COLOR_W-1:0]   color;

    modport source (output valid, output color, input ready);
    modport sink   (input valid, input color, output ready);
endinterface

### hw/rtl/hgc_div_cell.sv
// hgc_div_cell: one restoring division cell, yields one fraction bit per item
// depends on hgc_pkg for the division item type
module hgc_div_cell #(
    parameter int Q_W = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  hgc_pkg::t_div_item  i_item,
    input  logic [Q_W-1:0]      i_q,
    output logic                o_valid,
    output hgc_pkg::t_div_item  o_item,
    output logic [Q_W-1:0]      o_q
);

    logic                      r_valid;
    hgc_pkg::t_div_item        r_item;
    logic [Q_W-1:0]            r_q;

    logic [hgc_pkg::HEIGHT_W:0] w_sh;
    logic [hgc_pkg::HEIGHT_W:0] w_diff;
    logic                       w_ge;
    hgc_pkg::t_div_item         n_item;

    // remainder stays below den, so the shifted value fits one extra bit
    always_comb begin
        w_sh   = {i_item.rem, 1'b0};
        w_diff = w_sh - {1'b0, i_item.den};
        w_ge   = (w_sh >= {1'b0, i_item.den});
        n_item.den = i_item.den;
        n_item.rem = w_ge ? w_diff[hgc_pkg::HEIGHT_W-1:0] : w_sh[hgc_pkg::HEIGHT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
            r_q    <= {i_q[Q_W-2:0], w_ge};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_q     = r_q;

endmodule

### hw/rtl/hgc_blend.sv
// hgc_blend: per-channel weighting of start and end color by the fraction p
// depends on hgc_pkg for color and channel widths
module hgc_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [FRAC_BITS:0]            i_p,
    input  logic [hgc_pkg::COLOR_W-1:0]   i_start,
    input  logic [hgc_pkg::COLOR_W-1:0]   i_end,
    output logic                          o_valid,
    output logic [hgc_pkg::COLOR_W-1:0]   o_color
);

    localparam int CW     = hgc_pkg::CHAN_W;
    localparam int PROD_W = FRAC_BITS + CW + 3;

    logic                     r_valid;
    logic signed [PROD_W-1:0] r_prod [hgc_pkg::NUM_CHAN];
    logic signed [PROD_W-1:0] n_prod [hgc_pkg::NUM_CHAN];
    logic signed [PROD_W-1:0] w_sum  [hgc_pkg::NUM_CHAN];

    // e*p + s*(one-p) = s*one + (e-s)*p
    always_comb begin
        for (int c = 0; c < hgc_pkg::NUM_CHAN; c++) begin
            logic signed [CW:0]        d;
            logic signed [FRAC_BITS+1:0] ps;
            d  = $signed({1'b0, i_end[c*CW +: CW]}) - $signed({1'b0, i_start[c*CW +: CW]});
            ps = $signed({1'b0, i_p});
            n_prod[c] = PROD_W'(d * ps);
        end
    end

    always_comb begin
        for (int c = 0; c < hgc_pkg::NUM_CHAN; c++) begin
            w_sum[c] = r_prod[c] + $signed(PROD_W'({i_start[c*CW +: CW], {FRAC_BITS{1'b0}}}));
            o_color[c*CW +: CW] = w_sum[c][FRAC_BITS +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;

endmodule

### hw/rtl/height_to_gradient_color.sv
// height_to_gradient_color: maps a signed height to a color on a linear start/end gradient
// depends on hgc_pkg, hgc_height_if, hgc_color_if, hgc_div_cell and hgc_blend
//
//   port     dir  payload                handshake
//   i_hgt    in   height  16 bit signed  valid/ready, transfer on valid & ready
//   o_col    out  color   32 bit         valid/ready, transfer on valid & ready
//   i_cfg_*  in   index 3 bit, data 32   write when i_cfg_we high, no wait
//
// one height per cycle while the pipeline is not stalled; registers in order: a clamp stage, one division
// cell per fraction bit, a multiply stage and the output register
// i_hgt.ready falls only when the output register and the skid stage are both full;
// the whole pipeline then holds until o_col takes a color
// synchronous active-low reset clears valids and loads the register reset values
module height_to_gradient_color #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hgc_height_if.sink                       i_hgt,
    hgc_color_if.source                      o_col,
    input  logic                             i_cfg_we,
    input  hgc_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [hgc_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    localparam int HW  = hgc_pkg::HEIGHT_W;
    localparam int CW  = hgc_pkg::COLOR_W;
    localparam int Q_W = FRAC_BITS + 1;

    logic signed [HW-1:0] r_lo;
    logic signed [HW-1:0] r_hi;
    logic [CW-1:0]        r_start;
    logic [CW-1:0]        r_end;

    logic                 w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo    <= '0;
            r_hi    <= '0;
            r_start <= hgc_pkg::START_COLOR_RST;
            r_end   <= hgc_pkg::END_COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hgc_pkg::CFG_HEIGHT_LOW:  r_lo    <= i_cfg_data[HW-1:0];
                hgc_pkg::CFG_HEIGHT_HIGH: r_hi    <= i_cfg_data[HW-1:0];
                hgc_pkg::CFG_START_COLOR: r_start <= i_cfg_data[CW-1:0];
                hgc_pkg::CFG_END_COLOR:   r_end   <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // clamp stage: distances from the low end, integer bit of the fraction
    logic signed [HW-1:0] w_rmin, w_rmax, w_zc;
    logic signed [HW:0]   w_num, w_den;
    logic                 w_empty, w_top;
    hgc_pkg::t_div_item   n_f_item;
    logic [Q_W-1:0]       n_f_q;

    always_comb begin
        w_empty = (r_lo == r_hi);
        w_rmin  = (r_lo < r_hi) ? r_lo : r_hi;
        w_rmax  = (r_lo < r_hi) ? r_hi : r_lo;
        w_zc    = i_hgt.height;
        if (w_zc < w_rmin) begin
            w_zc = w_rmin;
        end
        if (w_zc > w_rmax) begin
            w_zc = w_rmax;
        end
        w_num = (w_zc >= r_lo) ? ({w_zc[HW-1], w_zc} - {r_lo[HW-1], r_lo})
                               : ({r_lo[HW-1], r_lo} - {w_zc[HW-1], w_zc});
        w_den = (r_hi > r_lo)  ? ({r_hi[HW-1], r_hi} - {r_lo[HW-1], r_lo})
                               : ({r_lo[HW-1], r_lo} - {r_hi[HW-1], r_hi});
        w_top = (w_zc == r_hi);
        // empty range: 0/1 with the integer bit set gives p = one, i.e. end color
        if (w_empty) begin
            n_f_item.rem = '0;
            n_f_item.den = HW'(1);
            n_f_q        = Q_W'(1);
        end else begin
            n_f_item.rem = w_top ? '0 : w_num[HW-1:0];
            n_f_item.den = w_den[HW-1:0];
            n_f_q        = {{(Q_W-1){1'b0}}, w_top};
        end
    end

    logic               r_f_v;
    hgc_pkg::t_div_item r_f_item;
    logic [Q_W-1:0]     r_f_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= i_hgt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_item <= n_f_item;
            r_f_q    <= n_f_q;
        end
    end

    // row of division cells, one fraction bit each
    logic               w_v    [FRAC_BITS+1];
    hgc_pkg::t_div_item w_item [FRAC_BITS+1];
    logic [Q_W-1:0]     w_q    [FRAC_BITS+1];

    assign w_v[0]    = r_f_v;
    assign w_item[0] = r_f_item;
    assign w_q[0]    = r_f_q;

    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_cell
        hgc_div_cell #(
            .Q_W (Q_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_item  (w_item[g]),
            .i_q     (w_q[g]),
            .o_valid (w_v[g+1]),
            .o_item  (w_item[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    logic          w_b_v;
    logic [CW-1:0] w_b_color;

    hgc_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v[FRAC_BITS]),
        .i_p     (w_q[FRAC_BITS]),
        .i_start (r_start),
        .i_end   (r_end),
        .o_valid (w_b_v),
        .o_color (w_b_color)
    );

    // output register with skid stage
    logic          r_out_v, r_skid_v;
    logic [CW-1:0] r_out_color, r_skid_color;

    assign w_en        = !r_skid_v;
    assign i_hgt.ready = w_en;
    assign o_col.valid = r_out_v;
    assign o_col.color = r_out_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_col.ready) begin
                r_out_color <= r_skid_color;
                r_skid_v    <= 1'b0;
            end
        end else if (w_b_v) begin
            if (!r_out_v || o_col.ready) begin
                r_out_v     <= 1'b1;
                r_out_color <= w_b_color;
            end else begin
                r_skid_v     <= 1'b1;
                r_skid_color <= w_b_color;
            end
        end else if (o_col.ready) begin
            r_out_v <= 1'b0;
        end
    end

endmodule

### hw/rtl/hgc_checker.sv
// hgc_checker: port-level properties of height_to_gradient_color, and its bind
// depends only on the top level's ports
module hgc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_ready,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_color
);

    // a pending color holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_color))
        else $error("output color changed or dropped while stalled");

    // input backpressure only when the output side is full
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending output");

    // skid stage drains only through an output transfer
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready && !i_out_ready |=> !i_in_ready)
        else $error("input ready rose without an output transfer");

    // right after reset the block is empty and open
    a_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("block not empty after reset");

endmodule

bind height_to_gradient_color hgc_checker u_hgc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_hgt.ready),
    .i_out_valid (o_col.valid),
    .i_out_ready (o_col.ready),
    .i_out_color (o_col.color)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for height_to_gradient_color, corner heights then random ones
// depends on hgc_pkg, hgc_height_if, hgc_color_if and the height_to_gradient_color block
module tb_top;

    localparam int HEIGHT_W    = hgc_pkg::HEIGHT_W;
    localparam int COLOR_W     = hgc_pkg::COLOR_W;
    localparam int CHAN_W      = hgc_pkg::CHAN_W;
    localparam int NUM_CHAN    = hgc_pkg::NUM_CHAN;
    localparam int CFG_DAT_W   = hgc_pkg::CFG_DAT_W;
    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = FRAC_BITS + 3;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 70;
    localparam int HOLD_CYCLES = 80;
    localparam longint unsigned FRAC_ONE = 64'd1 << FRAC_BITS;
    localparam hgc_pkg::t_cfg_idx CFG_IDX_MAX =
        hgc_pkg::t_cfg_idx'((1 << hgc_pkg::CFG_IDX_W) - 1);

    // expected colors in transfer order, plus the block's register copy
    class gradient_scoreboard;
        logic signed [HEIGHT_W-1:0] low_h;
        logic signed [HEIGHT_W-1:0] high_h;
        logic [COLOR_W-1:0]         start_c;
        logic [COLOR_W-1:0]         end_c;
        logic [COLOR_W-1:0]         color_q[$];
        int                         errors;
        int                         heights_seen;
        int                         colors_seen;

        function new();
            low_h        = '0;
            high_h       = '0;
            start_c      = hgc_pkg::START_COLOR_RST;
            end_c        = hgc_pkg::END_COLOR_RST;
            errors       = 0;
            heights_seen = 0;
            colors_seen  = 0;
        endfunction

        function void apply_reg(hgc_pkg::t_cfg_idx idx, logic [CFG_DAT_W-1:0] data);
            unique case (idx)
                hgc_pkg::CFG_HEIGHT_LOW:  low_h   = data[HEIGHT_W-1:0];
                hgc_pkg::CFG_HEIGHT_HIGH: high_h  = data[HEIGHT_W-1:0];
                hgc_pkg::CFG_START_COLOR: start_c = data[COLOR_W-1:0];
                hgc_pkg::CFG_END_COLOR:   end_c   = data[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [COLOR_W-1:0] blend(logic signed [HEIGHT_W-1:0] h);
            int                 z;
            int                 span_lo;
            int                 span_hi;
            int                 ch;
            longint unsigned    num;
            longint unsigned    den;
            longint unsigned    frac;
            longint unsigned    sum;
            logic [COLOR_W-1:0] c;
            if (low_h == high_h)
                return end_c;
            // reversed spans clamp the same way, gradient still starts at low_h
            span_lo = (low_h < high_h) ? low_h : high_h;
            span_hi = (low_h < high_h) ? high_h : low_h;
            z = h;
            if (z < span_lo)
                z = span_lo;
            if (z > span_hi)
                z = span_hi;
            num  = (z >= low_h) ? z - int'(low_h) : int'(low_h) - z;
            den  = (high_h > low_h) ? int'(high_h) - int'(low_h) : int'(low_h) - int'(high_h);
            frac = (num << FRAC_BITS) / den;
            if (frac > FRAC_ONE)
                frac = FRAC_ONE;
            c = '0;
            for (ch = 0; ch < NUM_CHAN; ch++) begin
                sum = longint'(end_c[ch*CHAN_W +: CHAN_W]) * frac
                    + longint'(start_c[ch*CHAN_W +: CHAN_W]) * (FRAC_ONE - frac);
                c[ch*CHAN_W +: CHAN_W] = CHAN_W'(sum >> FRAC_BITS);
            end
            return c;
        endfunction

        function void note_height(logic signed [HEIGHT_W-1:0] h);
            color_q.push_back(blend(h));
            heights_seen++;
        endfunction

        function int pending();
            return color_q.size();
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        task check_color(logic [COLOR_W-1:0] c);
            logic [COLOR_W-1:0] want;
            colors_seen++;
            if (color_q.size() == 0) begin
                report($sformatf("color %08h with no height waiting", c));
                return;
            end
            want = color_q.pop_front();
            if (c !== want)
                report($sformatf("color %08h, expected %08h", c, want));
        endtask

        task finish_check();
            if (color_q.size() != 0)
                report($sformatf("%0d colors never arrived", color_q.size()));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    hgc_pkg::t_cfg_idx    i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    hgc_height_if hgt_if();
    hgc_color_if  col_if();

    gradient_scoreboard sb;
    bit                 tx_idle_en;
    bit                 rx_idle_en;
    bit                 hold_req;
    int                 setting_count;

    height_to_gradient_color #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hgt      (hgt_if),
        .o_col      (col_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] pick_height();
        int a;
        int b;
        int r;
        a = (sb.low_h < sb.high_h) ? sb.low_h : sb.high_h;
        b = (sb.low_h < sb.high_h) ? sb.high_h : sb.low_h;
        r = $urandom_range(0, 9);
        if (r < 6)
            return HEIGHT_W'(a + int'($urandom_range(0, b - a)));
        if (r < 8)
            return HEIGHT_W'($urandom);
        if (r == 8)
            return HEIGHT_W'(($urandom_range(0, 1) ? a : b) - 1 + int'($urandom_range(0, 2)));
        return $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
    endfunction

    // entered and left at a falling edge; valid stays high when no gap follows
    task automatic send_height(logic signed [HEIGHT_W-1:0] h);
        int gap;
        hgt_if.valid  <= 1'b1;
        hgt_if.height <= h;
        @(posedge i_clk);
        while (!hgt_if.ready)
            @(posedge i_clk);
        sb.note_height(h);
        @(negedge i_clk);
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            hgt_if.valid  <= 1'b0;
            hgt_if.height <= HEIGHT_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic go_idle();
        hgt_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(hgc_pkg::t_cfg_idx idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.apply_reg(idx, data);
        @(negedge i_clk);
    endtask

    // also pokes an unmapped index, which must leave everything alone
    task automatic set_gradient(int lo, int hi, logic [COLOR_W-1:0] sc, logic [COLOR_W-1:0] ec);
        write_reg(hgc_pkg::t_cfg_idx'($urandom_range(hgc_pkg::CFG_END_COLOR + 1, CFG_IDX_MAX)),
                  $urandom);
        write_reg(hgc_pkg::CFG_HEIGHT_LOW, CFG_DAT_W'(lo));
        write_reg(hgc_pkg::CFG_HEIGHT_HIGH, CFG_DAT_W'(hi));
        write_reg(hgc_pkg::CFG_START_COLOR, sc);
        write_reg(hgc_pkg::CFG_END_COLOR, ec);
        i_cfg_we <= 1'b0;
        setting_count++;
    endtask

    task automatic random_gradient();
        int lo;
        int hi;
        int k;
        lo = $signed(HEIGHT_W'($urandom));
        hi = $signed(HEIGHT_W'($urandom));
        case ($urandom_range(0, 4))
            1: begin
                k  = $urandom_range(1, 16);
                hi = (lo + k > 32767) ? lo - k : lo + k;
            end
            2: hi = lo;
            3: begin
                lo = -32768;
                hi = 32767;
            end
            4: begin
                lo = int'($urandom_range(0, 2000)) - 1000;
                hi = int'($urandom_range(0, 2000)) - 1000;
            end
            default: ;
        endcase
        if ($urandom_range(0, 1)) begin
            k  = lo;
            lo = hi;
            hi = k;
        end
        set_gradient(lo, hi, $urandom, $urandom);
    endtask

    // color side: check on the rising edge, choose ready on the falling edge
    initial begin
        int hold;
        hold         = 0;
        col_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (col_if.valid && col_if.ready)
                sb.check_color(col_if.color);
            @(negedge i_clk);
            if (hold_req) begin
                hold     = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                col_if.ready <= 1'b0;
                hold--;
            end else begin
                col_if.ready <= 1'b1;
                if (rx_idle_en)
                    hold = pick_gap();
            end
        end
    end

    initial begin
        sb            = new();
        setting_count = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_req      = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = hgc_pkg::CFG_HEIGHT_LOW;
        i_cfg_data    = '0;
        hgt_if.valid  = 1'b0;
        hgt_if.height = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers give an empty range, so every height maps to the end color
        send_height(-16'sd32768);
        send_height(16'sd32767);
        send_height(16'sd0);
        send_height(-16'sd1);
        go_idle();

        // full span, widest divisor
        set_gradient(-32768, 32767, 32'h0000_0000, 32'hFFFF_FFFF);
        send_height(-16'sd32768);
        send_height(16'sd32767);
        send_height(16'sd0);
        send_height(-16'sd1);
        send_height(16'sd1);
        send_height(16'sh5555);
        send_height(16'shAAAA);
        go_idle();

        // reversed span
        set_gradient(32767, -32768, 32'hFFFF_FFFF, 32'h0000_0000);
        send_height(-16'sd32768);
        send_height(16'sd32767);
        send_height(16'sd0);
        send_height(-16'sd1);
        go_idle();

        // one-step span with heights clamped from both sides
        set_gradient(100, 101, 32'h00FF_00FF, 32'hFF00_FF00);
        send_height(-16'sd32768);
        send_height(16'sd32767);
        send_height(16'sd99);
        send_height(16'sd100);
        send_height(16'sd101);
        send_height(16'sd102);
        go_idle();

        set_gradient(-5, -5, $urandom, $urandom);
        send_height(16'sd0);
        send_height(-16'sd5);
        send_height(16'sd32767);
        go_idle();

        set_gradient(-1000, 2000, 32'h1234_5678, 32'h8765_4321);
        send_height(-16'sd1000);
        send_height(16'sd500);
        send_height(16'sd2000);
        go_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_gradient();
            tx_idle_en = (ph != 0) && (ph % 3 != 1);
            rx_idle_en = (ph != 0) && (ph % 4 != 3);
            // output held off while heights keep coming, so the input must stall
            if (ph == 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
                hold_req   = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 2 && k == PHASE_ITEMS / 2)
                    go_idle();
                send_height(pick_height());
            end
            go_idle();
        end

        repeat (LATENCY + 5) @(posedge i_clk);
        sb.finish_check();
        $display("covered %0d heights and %0d colors over %0d gradient settings",
                 sb.heights_seen, sb.colors_seen, setting_count);
        $display("spans: reset, empty, reversed, one-step and full; with stalls on both sides");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### height_to_gradient_color.f
hw/rtl/hgc_pkg.sv
hw/rtl/hgc_height_if.sv
hw/rtl/hgc_color_if.sv
hw/rtl/hgc_div_cell.sv
hw/rtl/hgc_blend.sv
hw/rtl/height_to_gradient_color.sv
hw/rtl/hgc_checker.sv
test/tb_top.sv
